[design/tca_pkg.sv]
// tca_pkg: constants, types and helper functions for the tilt corrected amplitude block
// no dependencies; imported by tilt_corrected_accel_amplitude
`timescale 1ns / 1ps

package tca_pkg;

	localparam int SAMPLE_W = 12;
	localparam int MAG_W    = 11;
	localparam int SQ_W     = 21;
	localparam int ROOT_W   = 11;
	localparam int RANGE_W  = 2;

	localparam int SQRT_STEPS = 11;
	localparam int S3_STEPS   = 4;
	localparam int S4_STEPS   = 8;

	localparam logic [RANGE_W-1:0] RANGE_HALF_G = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_ONE_G  = 2'd1;
	localparam logic [RANGE_W-1:0] RANGE_TWO_G  = 2'd2;
	localparam logic [RANGE_W-1:0] RANGE_RESET  = RANGE_TWO_G;

	localparam logic [MAG_W-1:0] MASK_HALF_G = 11'h1FF;
	localparam logic [MAG_W-1:0] MASK_ONE_G  = 11'h3FF;
	localparam logic [MAG_W-1:0] MASK_TWO_G  = 11'h7FF;

	localparam logic [SQ_W-1:0]   Q10_ONE_SQ = 21'(1) << 20;
	localparam logic [ROOT_W-1:0] CLAMP_ROOT = 11'd144;
	localparam logic [ROOT_W-1:0] ROOT_MAX   = 11'd1024;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] res;
	} sq_t;

	function automatic logic [MAG_W-1:0] range_mask(input logic [RANGE_W-1:0] code);
		logic [MAG_W-1:0] m;
		case (code)
			RANGE_HALF_G: m = MASK_HALF_G;
			RANGE_ONE_G:  m = MASK_ONE_G;
			default:      m = MASK_TWO_G;
		endcase
		return m;
	endfunction

	function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] raw,
			input logic [MAG_W-1:0] mask);
		logic [MAG_W-1:0] low;
		logic [MAG_W-1:0] m;
		low = raw[MAG_W-1:0] & mask;
		if (raw[SAMPLE_W-1]) begin
			m = (MAG_W'(0) - low) & mask;
		end else begin
			m = low;
		end
		return m;
	endfunction

	// one digit of the bitwise integer square root
	function automatic sq_t sqrt_step(input sq_t a, input int k);
		logic [SQ_W-1:0] b;
		logic [SQ_W-1:0] t;
		sq_t r;
		b = SQ_W'(1) << (SQ_W - 1 - 2 * k);
		t = a.res + b;
		if (a.rem >= t) begin
			r.rem = a.rem - t;
			r.res = (a.res >> 1) + b;
		end else begin
			r.rem = a.rem;
			r.res = a.res >> 1;
		end
		return r;
	endfunction

endpackage

[design/tilt_corrected_accel_amplitude.sv]
// tilt_corrected_accel_amplitude: six stage pipeline giving |z - sqrt(1 - y^2)| in Q10
// depends on tca_pkg (constants, mask and square root step functions)
`timescale 1ns / 1ps

// Usage
// A request is a Y and a Z sample, taken at a rising edge where start is high and busy
// is low. busy stays low: a new request can be given every cycle.
// Each request gives one amplitude, shown for one cycle with done high once it has
// passed stages s1 to s5 and the output register; results leave in request order.
// Throughput is one request per cycle: the square and the eleven root digits are
// spread over stages (square, then four, four and three root digits, then the
// difference), each stage registered, so a request enters every cycle.
// The range register is written by cfg_we / cfg_wdata and should only be changed
// while no request is in flight; it applies to requests taken after the write.
// Reset clears all valid bits and sets the range to two g; requests in flight are lost.
// The receiver cannot stall: done is a one-cycle strobe and must be taken then.
module tilt_corrected_accel_amplitude
	import tca_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SAMPLE_W-1:0]  y_sample,
	input  logic [SAMPLE_W-1:0]  z_sample,
	input  logic                 cfg_we,
	input  logic [RANGE_W-1:0]   cfg_wdata,
	output logic                 done,
	output logic [ROOT_W-1:0]    amplitude
);

	logic [RANGE_W-1:0] range_q;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [MAG_W-1:0]  ymag_s1, zmag_s1;
	logic              clamp_s2, clamp_s3, clamp_s4;
	logic [MAG_W-1:0]  zmag_s2, zmag_s3, zmag_s4, zmag_s5;
	sq_t               sq_s2, sq_s3, sq_s4;
	logic [ROOT_W-1:0] root_s5;
	logic              done_q;
	logic [ROOT_W-1:0] amplitude_q;

	logic [MAG_W-1:0]  mask;
	logic              accept;
	logic [SQ_W-1:0]   ylow;
	logic [SQ_W-1:0]   ysq;
	sq_t               sq3_d, sq4_d, sq5_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign mask   = range_mask(range_q);
	assign ylow   = SQ_W'(ymag_s1[MAG_W-2:0]);
	assign ysq    = ylow * ylow;

	always_comb begin
		sq3_d = sq_s2;
		for (int k = 0; k < S3_STEPS; k++) sq3_d = sqrt_step(sq3_d, k);
	end

	always_comb begin
		sq4_d = sq_s3;
		for (int k = S3_STEPS; k < S4_STEPS; k++) sq4_d = sqrt_step(sq4_d, k);
	end

	always_comb begin
		sq5_d = sq_s4;
		for (int k = S4_STEPS; k < SQRT_STEPS; k++) sq5_d = sqrt_step(sq5_d, k);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q  <= RANGE_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) range_q <= cfg_wdata;
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			done_q   <= valid_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		ymag_s1 <= sample_mag(y_sample, mask);
		zmag_s1 <= sample_mag(z_sample, mask);

		clamp_s2   <= ymag_s1[MAG_W-1];
		zmag_s2    <= zmag_s1;
		sq_s2.rem  <= Q10_ONE_SQ - ysq;
		sq_s2.res  <= '0;

		clamp_s3 <= clamp_s2;
		zmag_s3  <= zmag_s2;
		sq_s3    <= sq3_d;

		clamp_s4 <= clamp_s3;
		zmag_s4  <= zmag_s3;
		sq_s4    <= sq4_d;

		zmag_s5 <= zmag_s4;
		root_s5 <= clamp_s4 ? CLAMP_ROOT : sq5_d.res[ROOT_W-1:0];

		if (zmag_s5 >= root_s5) begin
			amplitude_q <= zmag_s5 - root_s5;
		end else begin
			amplitude_q <= root_s5 - zmag_s5;
		end
	end

	assign done      = done_q;
	assign amplitude = amplitude_q;

`ifndef NO_ASSERTIONS
	a_done_follows_s5: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s5))
		else $error("done without a request in the last stage");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> root_s5 <= ROOT_MAX)
		else $error("root term above one g");

	a_clamp_root: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && clamp_s4 |=> root_s5 == CLAMP_ROOT)
		else $error("clamped request did not get the fixed root");

	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> $past(valid_s2) && $past(valid_s1, 2))
		else $error("valid bit skipped a stage");
`endif

endmodule
